>>> hw/rtl/kcgd_pkg.sv
// ----------------------------------------------------------------------------
// kcgd_pkg
// Item types, state type and codes shared by the key click gesture detector.
// ----------------------------------------------------------------------------
package kcgd_pkg;

   localparam int unsigned CodeWidth   = 10;
   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned WindowWidth = 16;

   localparam logic [WindowWidth-1:0] WINDOW_RESET = 16'd300;

   localparam logic OP_EVENT = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [1:0] VALUE_RELEASE = 2'd0;
   localparam logic [1:0] VALUE_PRESS   = 2'd1;
   localparam logic [1:0] VALUE_REPEAT  = 2'd2;

   localparam logic [1:0] ACTION_SINGLE = 2'd0;
   localparam logic [1:0] ACTION_DOUBLE = 2'd1;
   localparam logic [1:0] ACTION_LONG   = 2'd2;

   typedef struct packed {
      logic                 op;
      logic [CodeWidth-1:0] key_id;
      logic [1:0]           key_state;
      logic [TimeWidth-1:0] event_time_ms;
   } req_item_type;

   typedef struct packed {
      logic                 gesture_valid;
      logic [1:0]           action;
      logic [CodeWidth-1:0] gesture_code;
      logic [TimeWidth-1:0] long_press_ms;
   } rsp_item_type;

   typedef struct packed {
      logic                 valid;
      logic [CodeWidth-1:0] code;
      logic [1:0]           value;
      logic [TimeWidth-1:0] press_time;
   } cache_type;

endpackage

>>> hw/rtl/kcgd_decide.sv
// ----------------------------------------------------------------------------
// kcgd_decide
// Gesture decision for one item against the cached key: result and next cache.
// ----------------------------------------------------------------------------
module kcgd_decide (
   input  kcgd_pkg::req_item_type               item,
   input  kcgd_pkg::cache_type                  cache,
   input  logic [kcgd_pkg::WindowWidth-1:0]     window,
   output kcgd_pkg::rsp_item_type               result,
   output kcgd_pkg::cache_type                  cache_next
);

   logic [kcgd_pkg::TimeWidth-1:0] held;
   logic                           same;
   logic                           late;

   always_comb begin
      held = item.event_time_ms - cache.press_time;
      same = cache.valid && (cache.code == item.key_id);
      late = held > {{(kcgd_pkg::TimeWidth - kcgd_pkg::WindowWidth){1'b0}}, window};
      cache_next = cache;
      result     = '0;
      if (item.op == kcgd_pkg::OP_TICK) begin
         if (cache.valid && cache.value == kcgd_pkg::VALUE_RELEASE) begin
            result.gesture_valid = 1'b1;
            result.action        = kcgd_pkg::ACTION_SINGLE;
            result.gesture_code  = cache.code;
            cache_next.valid     = 1'b0;
         end
      end else begin
         case (item.key_state)
            kcgd_pkg::VALUE_PRESS: begin
               if (!cache.valid) begin
                  cache_next.valid      = 1'b1;
                  cache_next.code       = item.key_id;
                  cache_next.value      = kcgd_pkg::VALUE_PRESS;
                  cache_next.press_time = item.event_time_ms;
               end else if (same) begin
                  result.gesture_valid = 1'b1;
                  result.gesture_code  = item.key_id;
                  if (late) begin
                     result.action         = kcgd_pkg::ACTION_SINGLE;
                     cache_next.press_time = item.event_time_ms;
                     cache_next.value      = kcgd_pkg::VALUE_PRESS;
                  end else begin
                     result.action    = kcgd_pkg::ACTION_DOUBLE;
                     cache_next.valid = 1'b0;
                  end
               end else begin
                  // flush the other key
                  result.gesture_valid = 1'b1;
                  result.gesture_code  = cache.code;
                  if (cache.value == kcgd_pkg::VALUE_REPEAT) begin
                     result.action        = kcgd_pkg::ACTION_LONG;
                     result.long_press_ms = held;
                  end else begin
                     result.action = kcgd_pkg::ACTION_SINGLE;
                  end
                  cache_next.valid      = 1'b1;
                  cache_next.code       = item.key_id;
                  cache_next.value      = kcgd_pkg::VALUE_PRESS;
                  cache_next.press_time = item.event_time_ms;
               end
            end
            kcgd_pkg::VALUE_RELEASE: begin
               if (same) begin
                  if (cache.value == kcgd_pkg::VALUE_REPEAT) begin
                     result.gesture_valid = 1'b1;
                     result.action        = kcgd_pkg::ACTION_LONG;
                     result.gesture_code  = cache.code;
                     result.long_press_ms = held;
                     cache_next.valid     = 1'b0;
                  end else if (late) begin
                     result.gesture_valid = 1'b1;
                     result.action        = kcgd_pkg::ACTION_SINGLE;
                     result.gesture_code  = cache.code;
                     cache_next.valid     = 1'b0;
                  end
                  cache_next.value = kcgd_pkg::VALUE_RELEASE;
               end
            end
            kcgd_pkg::VALUE_REPEAT: begin
               if (same) begin
                  cache_next.value     = kcgd_pkg::VALUE_REPEAT;
                  result.gesture_valid = 1'b1;
                  result.action        = kcgd_pkg::ACTION_LONG;
                  result.gesture_code  = cache.code;
                  result.long_press_ms = held;
               end else begin
                  if (cache.valid && cache.value == kcgd_pkg::VALUE_RELEASE) begin
                     result.gesture_valid = 1'b1;
                     result.action        = kcgd_pkg::ACTION_SINGLE;
                     result.gesture_code  = cache.code;
                  end
                  cache_next.valid      = 1'b1;
                  cache_next.code       = item.key_id;
                  cache_next.value      = kcgd_pkg::VALUE_REPEAT;
                  cache_next.press_time = item.event_time_ms;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

>>> hw/rtl/key_click_gesture_detector_unit.sv
// path: an accepted item is registered in the input stage, then its result in the output stage
// throughput: one item per cycle while the result is not stalled, as the cache is updated with each item
// reset: synchronous, clears both stages, the cached key and sets the window to 300 ms
// ----------------------------------------------------------------------------
// key_click_gesture_detector_unit
// Turns timestamped key events and timeout ticks into single, double and
// long click gestures for one cached key.
// ----------------------------------------------------------------------------
module key_click_gesture_detector_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  kcgd_pkg::req_item_type             req_item,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output kcgd_pkg::rsp_item_type             rsp_item,
   input  logic                               csr_write_enable,
   input  logic [kcgd_pkg::WindowWidth-1:0]   csr_write_data
);

   logic                             in_valid_ff;
   logic                             in_valid_in;
   kcgd_pkg::req_item_type           in_item_ff;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   kcgd_pkg::rsp_item_type           rsp_item_ff;
   kcgd_pkg::cache_type              cache_ff;
   kcgd_pkg::cache_type              cache_in;
   logic [kcgd_pkg::WindowWidth-1:0] window_ff;
   kcgd_pkg::rsp_item_type           result;
   logic                             advance;
   logic                             req_take;

   kcgd_decide u_decide (
      .item       (in_item_ff),
      .cache      (cache_ff),
      .window     (window_ff),
      .result     (result),
      .cache_next (cache_in)
   );

   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cache_ff     <= '0;
         window_ff    <= kcgd_pkg::WINDOW_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            cache_ff <= cache_in;
         end
         if (csr_write_enable) begin
            window_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

>>> hw/rtl/kcgd_checker.sv
// ----------------------------------------------------------------------------
// kcgd_checker
// Port-level checks on the gesture results, bound to the top level.
// ----------------------------------------------------------------------------
module kcgd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input kcgd_pkg::rsp_item_type             rsp_item
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // empty result carries zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.gesture_valid |->
         rsp_item.action == kcgd_pkg::ACTION_SINGLE && rsp_item.gesture_code == '0 &&
         rsp_item.long_press_ms == '0)
      else $error("fields set without a gesture");

   // only a long click carries a held time
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.action != kcgd_pkg::ACTION_LONG |->
         rsp_item.long_press_ms == '0)
      else $error("held time on a short click");

   // action code in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.action == kcgd_pkg::ACTION_SINGLE ||
         rsp_item.action == kcgd_pkg::ACTION_DOUBLE ||
         rsp_item.action == kcgd_pkg::ACTION_LONG)
      else $error("unknown action code");

   // reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

bind key_click_gesture_detector_unit kcgd_checker u_kcgd_checker (.*);
